### rtl/core/tlr_pkg.sv
// Shared types, codes and constants for the terminated line receiver.
`default_nettype none

package tlr_pkg;

    localparam int BUFFER_DEPTH_DEF = 64;

    localparam int ACT_W     = 2;
    localparam int BYTE_W    = 8;
    localparam int IDX_W     = 6;
    localparam int EV_W      = 3;
    localparam int LEN_W     = 6;
    localparam int CFG_IDX_W = 1;

    localparam logic [ACT_W-1:0] ACT_BYTE    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_TICK    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd2;
    localparam logic [ACT_W-1:0] ACT_READ    = 2'd3;

    localparam logic [EV_W-1:0] EV_NONE     = 3'd0;
    localparam logic [EV_W-1:0] EV_STORED   = 3'd1;
    localparam logic [EV_W-1:0] EV_COMPLETE = 3'd2;
    localparam logic [EV_W-1:0] EV_OVERFLOW = 3'd3;
    localparam logic [EV_W-1:0] EV_BUSY     = 3'd4;
    localparam logic [EV_W-1:0] EV_TIMEOUT  = 3'd5;
    localparam logic [EV_W-1:0] EV_READ     = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_TERMINATOR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 1'd1;

    localparam logic [BYTE_W-1:0] TERMINATOR_RESET = 8'd10;
    localparam logic [BYTE_W-1:0] TIMEOUT_RESET    = 8'd100;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [BYTE_W-1:0] rx_byte;
        logic [IDX_W-1:0]  read_index;
    } item_t;

    typedef struct packed {
        logic [EV_W-1:0]  event_res;
        logic             message_ready;
        logic [LEN_W-1:0] message_length;
        logic             read_ok;
        logic             timeout_active;
    } res_t;

endpackage

`default_nettype wire

### rtl/core/tlr_if.sv
// Valid/ready channel interfaces for input beats and result beats.
`default_nettype none

interface tlr_in_if;
    import tlr_pkg::*;

    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [BYTE_W-1:0] rx_byte;
    logic [IDX_W-1:0]  read_index;

    modport source (output valid, output action, output rx_byte, output read_index,
                    input ready);
    modport sink (input valid, input action, input rx_byte, input read_index,
                  output ready);
endinterface

interface tlr_out_if;
    import tlr_pkg::*;

    logic              valid;
    logic              ready;
    logic [EV_W-1:0]   event_res;
    logic              message_ready;
    logic [LEN_W-1:0]  message_length;
    logic [BYTE_W-1:0] read_data;
    logic              timeout_active;

    modport source (output valid, output event_res, output message_ready,
                    output message_length, output read_data, output timeout_active,
                    input ready);
    modport sink (input valid, input event_res, input message_ready,
                  input message_length, input read_data, input timeout_active,
                  output ready);
endinterface

`default_nettype wire

### rtl/core/terminated_line_receiver_timeout.sv
// Top level of the terminated line receiver with inter-byte timeout.
// An accepted input beat is registered in the input stage, then in the result stage.
// Throughput: one beat per cycle while results are taken; up to two beats are held while results stall.
// Reset clears the write position, length, ready flag, timer and both stages;
// terminator resets to newline and the timeout to 100 ticks.
// Line buffer contents are undefined until written; no clearing pass.
`default_nettype none

module terminated_line_receiver_timeout #(
    parameter int BUFFER_DEPTH = tlr_pkg::BUFFER_DEPTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_write,
    input  wire logic [tlr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tlr_pkg::BYTE_W-1:0]    cfg_data,
    tlr_in_if.sink                            items,
    tlr_out_if.source                         results
);
    import tlr_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);

    logic              s0_valid_reg;
    item_t             s0_item_reg;
    logic              out_valid_reg;
    res_t              res_reg;
    res_t              res_next;
    logic              s0_move;
    logic              in_fire;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [BYTE_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [BYTE_W-1:0] rd_data;

    assign s0_move     = s0_valid_reg && (!out_valid_reg || results.ready);
    assign items.ready = !s0_valid_reg || s0_move;
    assign in_fire     = items.valid && items.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (items.ready)
        begin
            s0_valid_reg <= items.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s0_item_reg.action     <= items.action;
            s0_item_reg.rx_byte    <= items.rx_byte;
            s0_item_reg.read_index <= items.read_index;
        end
    end

    tlr_ctrl #(
        .DEPTH (BUFFER_DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (s0_move),
        .item      (s0_item_reg),
        .res       (res_next),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr)
    );

    tlr_line_mem #(
        .DEPTH (BUFFER_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s0_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_move)
        begin
            res_reg <= res_next;
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.event_res      = res_reg.event_res;
    assign results.message_ready  = res_reg.message_ready;
    assign results.message_length = res_reg.message_length;
    assign results.timeout_active = res_reg.timeout_active;
    assign results.read_data      = res_reg.read_ok ? rd_data : '0;

    a_s0_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s0_valid_reg && !s0_move) |=> s0_valid_reg)
        else $error("input stage beat lost while blocked");

    a_move_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        s0_move |=> out_valid_reg)
        else $error("advanced beat missing from result stage");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !results.ready) |=> ($stable(res_reg) && $stable(rd_data)))
        else $error("stalled result or read data changed");

endmodule

`default_nettype wire

### rtl/core/tlr_line_mem.sv
// Line buffer memory: one write port, one registered read port.
`default_nettype none

module tlr_line_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic                      clk,
    input  wire logic                      we,
    input  wire logic [AW-1:0]             waddr,
    input  wire logic [tlr_pkg::BYTE_W-1:0] wdata,
    input  wire logic                      re,
    input  wire logic [AW-1:0]             raddr,
    output logic      [tlr_pkg::BYTE_W-1:0] rdata
);
    import tlr_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/core/tlr_ctrl.sv
// Receiver state, configuration registers and per-beat update logic.
`default_nettype none

module tlr_ctrl #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_write,
    input  wire logic [tlr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tlr_pkg::BYTE_W-1:0]    cfg_data,
    input  wire logic                         step,
    input  wire tlr_pkg::item_t               item,
    output tlr_pkg::res_t                     res,
    output logic                              mem_we,
    output logic      [AW-1:0]                mem_waddr,
    output logic      [tlr_pkg::BYTE_W-1:0]    mem_wdata,
    output logic                              mem_re,
    output logic      [AW-1:0]                mem_raddr
);
    import tlr_pkg::*;

    localparam int PW = $clog2(DEPTH + 1);
    localparam int CW = (PW > IDX_W) ? PW : IDX_W;

    logic [BYTE_W-1:0] terminator_reg;
    logic [BYTE_W-1:0] timeout_reg;

    logic [PW-1:0]     wp_reg, wp_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic              ready_flag_reg, ready_flag_next;
    logic              timer_reg, timer_next;
    logic [BYTE_W-1:0] tick_reg, tick_next;
    logic [BYTE_W-1:0] tick_inc;
    logic              idx_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            terminator_reg <= TERMINATOR_RESET;
            timeout_reg    <= TIMEOUT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_TERMINATOR: terminator_reg <= cfg_data;
                CFG_TIMEOUT:    timeout_reg    <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign tick_inc  = tick_reg + 8'd1;
    assign idx_ok    = CW'(item.read_index) < CW'(DEPTH);
    assign mem_waddr = wp_reg[AW-1:0];
    assign mem_raddr = AW'(item.read_index);

    always_comb
    begin
        wp_next         = wp_reg;
        len_next        = len_reg;
        ready_flag_next = ready_flag_reg;
        timer_next      = timer_reg;
        tick_next       = tick_reg;
        mem_we          = 1'b0;
        mem_wdata       = item.rx_byte;
        mem_re          = 1'b0;
        res.event_res   = EV_NONE;
        res.read_ok     = 1'b0;

        unique case (item.action)
            ACT_BYTE:
            begin
                if (ready_flag_reg)
                begin
                    res.event_res = EV_BUSY;
                end
                else if (wp_reg == PW'(DEPTH))
                begin
                    wp_next       = '0;
                    res.event_res = EV_OVERFLOW;
                end
                else if (item.rx_byte == terminator_reg)
                begin
                    mem_we          = step;
                    mem_wdata       = '0;
                    len_next        = LEN_W'(wp_reg);
                    wp_next         = '0;
                    ready_flag_next = 1'b1;
                    timer_next      = 1'b0;
                    tick_next       = '0;
                    res.event_res   = EV_COMPLETE;
                end
                else
                begin
                    mem_we        = step;
                    wp_next       = wp_reg + PW'(1);
                    timer_next    = 1'b1;
                    tick_next     = '0;
                    res.event_res = EV_STORED;
                end
            end
            ACT_TICK:
            begin
                if (timer_reg)
                begin
                    if (tick_inc >= timeout_reg)
                    begin
                        tick_next       = '0;
                        wp_next         = '0;
                        len_next        = '0;
                        ready_flag_next = 1'b0;
                        timer_next      = 1'b0;
                        res.event_res   = EV_TIMEOUT;
                    end
                    else
                    begin
                        tick_next = tick_inc;
                    end
                end
            end
            ACT_RELEASE:
            begin
                ready_flag_next = 1'b0;
            end
            ACT_READ:
            begin
                mem_re        = step && idx_ok;
                res.read_ok   = idx_ok;
                res.event_res = EV_READ;
            end
            default: ;
        endcase

        res.message_ready  = ready_flag_next;
        res.message_length = len_next;
        res.timeout_active = timer_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg         <= '0;
            len_reg        <= '0;
            ready_flag_reg <= 1'b0;
            timer_reg      <= 1'b0;
            tick_reg       <= '0;
        end
        else if (step)
        begin
            wp_reg         <= wp_next;
            len_reg        <= len_next;
            ready_flag_reg <= ready_flag_next;
            timer_reg      <= timer_next;
            tick_reg       <= tick_next;
        end
    end

    // a completed line stops the timer and only a new stored byte restarts it
    a_ready_stops_timer: assert property (@(posedge clk) disable iff (!rst_n)
        !(ready_flag_reg && timer_reg))
        else $error("timer running with message ready");

    a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wp_reg <= PW'(DEPTH))
        else $error("write position beyond buffer depth");

    a_write_only_on_byte: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (step && item.action == ACT_BYTE && !ready_flag_reg
                    && wp_reg != PW'(DEPTH)))
        else $error("buffer write outside an accepted byte");

endmodule

`default_nettype wire
